/* src/tsb_pkg.sv */
// shared types, constants and helpers for the tridiagonal sturm bisection block
`timescale 1ns / 1ps
`default_nettype none
package tsb_pkg;

    // matrix store depth and search length
    localparam int MAX_ORDER     = 256;
    localparam int BISECT_ROUNDS = 48;
    localparam int ADDR_W        = $clog2(MAX_ORDER);
    localparam int CNT_W         = $clog2(MAX_ORDER + 1);
    localparam int ROUND_W       = $clog2(BISECT_ROUNDS);

    // number format, signed Q16.32
    localparam int Q_W   = 48;
    localparam int RAD_W = 47;

    // divider sizes
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration port
    localparam int                    CFG_ADDR_W  = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LARGEST = CFG_ADDR_W'(1);
    localparam logic [RAD_W-1:0]      RADIUS_RST  = 47'h0002_0000_0000;

    localparam logic signed [Q_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0] NEG_MIN = 48'sh8000_0000_0000;

    typedef logic signed [Q_W-1:0] t_q48;

    // one stored row
    typedef struct packed {
        t_q48 diag;
        t_q48 off;
    } t_row;

    // status and result of the quotient unit
    typedef struct packed {
        logic done;
        logic sat;
        t_q48 q;
    } t_quot_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_UPD,
        S_QUOT,
        S_DECIDE,
        S_DONE
    } t_seq_state;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_MUL,
        Q_CHK,
        Q_DIV,
        Q_FIN
    } t_quot_state;

    // saturate a 49-bit difference to 48 bits
    function automatic t_q48 clamp49(input logic signed [Q_W:0] v);
        if (v[Q_W] != v[Q_W-1]) begin
            return v[Q_W] ? NEG_MIN : POS_MAX;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic sat49(input logic signed [Q_W:0] v);
        return v[Q_W] ^ v[Q_W-1];
    endfunction

endpackage
`default_nettype wire

/* src/tsb_row_mem.sv */
// row store: diagonal and off-diagonal pair per row, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module tsb_row_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [tsb_pkg::ADDR_W-1:0] i_waddr,
    input  tsb_pkg::t_row             i_wdata,
    input  logic                      i_re,
    input  logic [tsb_pkg::ADDR_W-1:0] i_raddr,
    output tsb_pkg::t_row             o_rdata
);
    import tsb_pkg::*;

    t_row mem [MAX_ORDER];
    t_row r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/tsb_quot.sv */
// quotient unit: b*b/d by partial products and a radix-2 restoring divider
`timescale 1ns / 1ps
`default_nettype none
module tsb_quot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tsb_pkg::t_q48      i_b,
    input  tsb_pkg::t_q48      i_d,
    output tsb_pkg::t_quot_res o_res
);
    import tsb_pkg::*;

    t_quot_state r_state, n_state;

    logic [Q_W-1:0]       r_m;
    logic [Q_W-1:0]       r_dm;
    logic                 r_dneg;
    logic [1:0]           r_step;
    logic [2*Q_W-1:0]     r_acc;
    logic [Q_W:0]         r_rem;
    logic [Q_W-1:0]       r_dvd;
    logic [Q_W-1:0]       r_quo;
    logic                 r_big;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic                 r_sat;
    t_q48                 r_q;

    logic signed [Q_W:0]  w_b_ext, w_d_ext, w_b_abs, w_d_abs;
    t_q48                 w_d_fix;
    logic [23:0]          w_ma, w_mb;
    logic [47:0]          w_pp;
    logic [2*Q_W-1:0]     w_term;
    logic                 w_big;
    logic [Q_W:0]         w_rem2;
    logic                 w_ge;
    logic [Q_W:0]         w_mag;
    logic [Q_W:0]         w_neg;
    t_q48                 w_q;
    logic                 w_sat;

    // magnitudes; a zero pivot is taken as one lsb
    assign w_d_fix = (i_d == '0) ? t_q48'(1) : i_d;
    assign w_b_ext = {i_b[Q_W-1], i_b};
    assign w_d_ext = {w_d_fix[Q_W-1], w_d_fix};
    assign w_b_abs = i_b[Q_W-1] ? -w_b_ext : w_b_ext;
    assign w_d_abs = w_d_fix[Q_W-1] ? -w_d_ext : w_d_ext;

    // one 24x24 partial product per step
    assign w_ma = (r_step == 2'd0) ? r_m[23:0] : r_m[47:24];
    assign w_mb = (r_step == 2'd2) ? r_m[47:24] : r_m[23:0];
    assign w_pp = w_ma * w_mb;

    always_comb begin
        case (r_step)
            2'd0:    w_term = {48'd0, w_pp};
            2'd1:    w_term = {23'd0, w_pp, 25'd0};
            default: w_term = {w_pp, 48'd0};
        endcase
    end

    // quotient does not fit 48 bits when the upper half already reaches the divisor
    assign w_big = r_acc[2*Q_W-1:Q_W] >= r_dm;

    // restoring divide step
    assign w_rem2 = {r_rem[Q_W-1:0], r_dvd[Q_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_dm};

    // sign and clamp the quotient
    assign w_mag = r_big ? {1'b1, {Q_W{1'b0}}} : {1'b0, r_quo};
    assign w_neg = -w_mag;
    always_comb begin
        if (!r_dneg) begin
            w_sat = w_mag >= {2'b01, {(Q_W-1){1'b0}}};
            w_q   = w_sat ? POS_MAX : w_mag[Q_W-1:0];
        end else begin
            w_sat = w_mag > {2'b01, {(Q_W-1){1'b0}}};
            w_q   = w_sat ? NEG_MIN : w_neg[Q_W-1:0];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == Q_FIN);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            Q_IDLE: if (i_start) n_state = Q_MUL;
            Q_MUL:  if (r_step == 2'd2) n_state = Q_CHK;
            Q_CHK:  n_state = w_big ? Q_FIN : Q_DIV;
            Q_DIV:  if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = Q_FIN;
            Q_FIN:  n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            Q_IDLE: begin
                r_m    <= w_b_abs[Q_W-1:0];
                r_dm   <= w_d_abs[Q_W-1:0];
                r_dneg <= w_d_fix[Q_W-1];
                r_step <= 2'd0;
            end
            Q_MUL: begin
                r_acc  <= (r_step == 2'd0) ? w_term : r_acc + w_term;
                r_step <= r_step + 2'd1;
            end
            Q_CHK: begin
                r_big <= w_big;
                r_rem <= {1'b0, r_acc[2*Q_W-1:Q_W]};
                r_dvd <= r_acc[Q_W-1:0];
                r_quo <= '0;
                r_cnt <= '0;
            end
            Q_DIV: begin
                r_rem <= w_ge ? w_rem2 - {1'b0, r_dm} : w_rem2;
                r_dvd <= {r_dvd[Q_W-2:0], 1'b0};
                r_quo <= {r_quo[Q_W-2:0], w_ge};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            Q_FIN: begin
                r_q   <= w_q;
                r_sat <= w_sat;
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.q    = r_q;

endmodule
`default_nettype wire

/* src/tridiagonal_sturm_bisection.sv */
// top level: row loading, sturm count sequencer and bisection of the search interval
//
// channel  dir  contents (lsb first)                         transfer when
// s        in   tdata: diagonal[47:0], off_diagonal[95:48]    i_s_tvalid & o_s_tready
//               tlast: last row, starts the search
// m        out  tdata: eigen_estimate[47:0], rows_used[56:48], o_m_tvalid & i_m_tready
//               overflow[57], zero fill [63:58]
// cfg      in   index 0 search_radius, 1 find_largest         i_cfg_we
//
// rows load one per cycle while the sequencer is idle
// a search runs BISECT_ROUNDS rounds over the k rows and is paced by the shared quotient unit:
// 3 multiply steps, 1 check and up to 48 divide steps for each row but the last
// reset is synchronous; the row store needs no clearing, only rows of the current matrix are read
// a finished result waits in the output register; rows of the next matrix load meanwhile
`timescale 1ns / 1ps
`default_nettype none
module tridiagonal_sturm_bisection (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [95:0]                   i_s_tdata,   // diagonal, off_diagonal
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [63:0]                   o_m_tdata,   // eigen_estimate, rows_used, overflow
    input  logic                          i_cfg_we,
    input  logic [tsb_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tsb_pkg::RAD_W-1:0]     i_cfg_data
);
    import tsb_pkg::*;

    t_seq_state r_state, n_state;

    logic [CNT_W-1:0]   r_row_count;
    logic               r_dropped;
    logic [RAD_W-1:0]   r_radius;
    logic               r_largest;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic [CNT_W-1:0]   r_k;
    t_q48               r_lo, r_hi, r_mid;
    logic [ADDR_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic [ROUND_W-1:0] r_round;
    logic               r_first;
    logic               r_sat;

    logic               w_in_xfer;
    logic               w_full;
    logic [CNT_W-1:0]   w_k_next;
    t_row               w_wrow, w_rrow;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic signed [Q_W:0] w_sum, w_t49, w_u49;
    t_q48               w_mid, w_t, w_qv, w_d_new;
    logic               w_sat_upd;
    logic               w_last_row;
    logic               w_go_low;
    logic               w_out_free;
    logic               w_q_start;
    t_quot_res          w_qres;
    logic signed [Q_W:0] w_rad_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid & o_s_tready;
    assign w_full     = (r_row_count == CNT_W'(MAX_ORDER));
    assign w_k_next   = w_full ? r_row_count : r_row_count + CNT_W'(1);
    assign w_wrow.diag = i_s_tdata[47:0];
    assign w_wrow.off  = i_s_tdata[95:48];

    // read row 0 at round start, the next row when its quotient is ready
    assign w_re    = (r_state == S_START) | ((r_state == S_QUOT) & w_qres.done);
    assign w_raddr = (r_state == S_START) ? '0 : r_idx;

    tsb_row_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer & ~w_full),
        .i_waddr (r_row_count[ADDR_W-1:0]),
        .i_wdata (w_wrow),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rrow)
    );

    // interval midpoint, floor of the half sum
    assign w_sum = {r_lo[Q_W-1], r_lo} + {r_hi[Q_W-1], r_hi};
    assign w_mid = w_sum[Q_W:1];

    // pivot update
    assign w_t49   = {w_rrow.diag[Q_W-1], w_rrow.diag} - {r_mid[Q_W-1], r_mid};
    assign w_t     = clamp49(w_t49);
    assign w_qv    = r_first ? '0 : w_qres.q;
    assign w_u49   = {w_t[Q_W-1], w_t} - {w_qv[Q_W-1], w_qv};
    assign w_d_new = clamp49(w_u49);
    assign w_sat_upd = sat49(w_t49) | sat49(w_u49) | (~r_first & w_qres.sat);
    assign w_last_row = (CNT_W'(r_idx) + CNT_W'(1)) == r_k;
    assign w_q_start  = (r_state == S_UPD) & ~w_last_row;

    tsb_quot u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_q_start),
        .i_b     (w_rrow.off),
        .i_d     (w_d_new),
        .o_res   (w_qres)
    );

    // which half keeps the wanted eigenvalue
    assign w_go_low   = r_largest ? (r_cnt >= r_k) : (r_cnt != '0);
    assign w_out_free = ~r_out_valid | i_m_tready;
    assign w_rad_ext  = {2'b00, r_radius};

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_xfer && i_s_tlast) n_state = S_START;
            S_START:  n_state = S_UPD;
            S_UPD:    n_state = w_last_row ? S_DECIDE : S_QUOT;
            S_QUOT:   if (w_qres.done) n_state = S_UPD;
            S_DECIDE: n_state = (r_round == ROUND_W'(BISECT_ROUNDS - 1)) ? S_DONE : S_START;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // matrix bookkeeping, registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
            r_dropped   <= 1'b0;
            r_radius    <= RADIUS_RST;
            r_largest   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RADIUS:  r_radius  <= i_cfg_data;
                    REG_LARGEST: r_largest <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                if (w_full) r_dropped <= 1'b1;
                else        r_row_count <= w_k_next;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_row_count <= '0;
                r_dropped   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k     <= w_k_next;
                r_hi    <= w_rad_ext[Q_W-1:0];
                r_lo    <= t_q48'(-w_rad_ext);
                r_round <= '0;
                r_sat   <= 1'b0;
            end
            S_START: begin
                r_mid   <= w_mid;
                r_idx   <= '0;
                r_cnt   <= '0;
                r_first <= 1'b1;
            end
            S_UPD: begin
                r_first <= 1'b0;
                r_sat   <= r_sat | w_sat_upd;
                r_cnt   <= r_cnt + CNT_W'(w_d_new[Q_W-1]);
                if (!w_last_row) r_idx <= r_idx + ADDR_W'(1);
            end
            S_DECIDE: begin
                if (w_go_low) r_hi <= r_mid;
                else          r_lo <= r_mid;
                r_round <= r_round + ROUND_W'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= {6'd0, r_dropped | r_sat, 9'(r_k), w_mid};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_count <= CNT_W'(MAX_ORDER))
        else $error("row count beyond store depth");

    a_quot_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qres.done |-> (r_state == S_QUOT))
        else $error("quotient finished while sequencer not waiting");

    a_idx_in_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (CNT_W'(r_idx) < r_k))
        else $error("row index past matrix order");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_row_count == '0 && r_out_valid))
        else $error("result load did not reset the matrix");

endmodule
`default_nettype wire
